@@ src/gbs_pkg.sv @@
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants, register indexes and control structs for the greedy
// box suppression unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

    // Default sizing
    localparam int MAX_KEPT_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;

    // Fixed field widths
    localparam int CLASS_W   = 8;
    localparam int SLOT_W    = 6;
    localparam int THR_W     = 9;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_AGNOSTIC = 4'd1;

    // Register reset values (115/256 is about 0.45)
    localparam logic [THR_W-1:0] IOU_THR_RESET = 9'd115;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // latch candidate, restart scan
        logic issue;   // read next kept entry into compare pipe
        logic commit;  // decide, append, load result register
    } gbs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;  // every kept entry has been issued
        logic pipe_busy;  // compares still in flight
        logic out_free;   // result register can take a beat
    } gbs_stat_t;

endpackage

`default_nettype wire

@@ src/gbs_box_if.sv @@
// ----------------------------------------------------------------------------
// gbs_box_if
// Candidate box channel: valid/ready plus box payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbs_box_if
    import gbs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] box_left;
    logic signed [COORD_BITS-1:0] box_top;
    logic        [COORD_BITS-1:0] box_width;
    logic        [COORD_BITS-1:0] box_height;
    logic        [CLASS_W-1:0]    box_class;
    logic                         first_box;

    modport source (
        output valid, box_left, box_top, box_width, box_height, box_class, first_box,
        input  ready
    );

    modport sink (
        input  valid, box_left, box_top, box_width, box_height, box_class, first_box,
        output ready
    );
endinterface

`default_nettype wire

@@ src/gbs_result_if.sv @@
// ----------------------------------------------------------------------------
// gbs_result_if
// Result channel: valid/ready plus keep decision payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbs_result_if
    import gbs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              kept;
    logic [SLOT_W-1:0] kept_slot;
    logic              list_full_drop;

    modport source (
        output valid, kept, kept_slot, list_full_drop,
        input  ready
    );

    modport sink (
        input  valid, kept, kept_slot, list_full_drop,
        output ready
    );
endinterface

`default_nettype wire

@@ src/gbs_cfg_if.sv @@
// ----------------------------------------------------------------------------
// gbs_cfg_if
// Configuration write channel: valid/ready, register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbs_cfg_if
    import gbs_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

@@ src/greedy_box_suppression_unit.sv @@
// Flow: after a candidate beat, one kept box is compared per cycle through the
//   single read port of the kept-list memory, then a five-stage compare pipe drains
//   and the decision is committed into the result register.
// Candidates are taken one at a time, only when the sequencer is idle; a new
//   candidate is taken while the previous result beat still waits in the result
//   register, and a stalled result beat holds the next decision until it leaves.
// Reset: list empty, threshold 115/256, class-aware mode; memory is not cleared.
// ----------------------------------------------------------------------------
// greedy_box_suppression_unit
// Greedy non-maximum suppression over score-sorted boxes with an
// integer overlap test: intersection*256 > threshold*union.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_box_suppression_unit
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT   = MAX_KEPT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    gbs_box_if.sink       candidate,
    gbs_result_if.source  result,
    gbs_cfg_if.sink       cfg
);

    gbs_cmd_t  cmd;
    gbs_stat_t stat;
    logic      in_ready;
    logic      res_valid;
    logic      res_kept;
    logic [SLOT_W-1:0] res_slot;
    logic      res_drop;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    assign candidate.ready      = in_ready;
    assign result.valid         = res_valid;
    assign result.kept          = res_kept;
    assign result.kept_slot     = res_slot;
    assign result.list_full_drop = res_drop;

    // Sequencer
    gbs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (candidate.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Storage and compare datapath
    gbs_datapath #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .box_left       (candidate.box_left),
        .box_top        (candidate.box_top),
        .box_width      (candidate.box_width),
        .box_height     (candidate.box_height),
        .box_class      (candidate.box_class),
        .first_box      (candidate.first_box),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_valid      (res_valid),
        .out_ready      (result.ready),
        .kept           (res_kept),
        .kept_slot      (res_slot),
        .list_full_drop (res_drop)
    );

endmodule

`default_nettype wire

@@ src/gbs_controller.sv @@
// ----------------------------------------------------------------------------
// gbs_controller
// Sequencer: accept a candidate, scan the kept list, drain the compare
// pipe, then commit the decision into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_controller
    import gbs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output gbs_cmd_t       cmd,
    input  wire gbs_stat_t stat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                    state_next = ST_DRAIN;
                else
                    cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ src/gbs_datapath.sv @@
// ----------------------------------------------------------------------------
// gbs_datapath
// Kept-box memory, candidate registers, five-stage overlap compare pipe,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_datapath
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT   = MAX_KEPT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gbs_cmd_t                     cmd,
    output gbs_stat_t                         stat,
    // candidate payload
    input  wire logic signed [COORD_BITS-1:0] box_left,
    input  wire logic signed [COORD_BITS-1:0] box_top,
    input  wire logic        [COORD_BITS-1:0] box_width,
    input  wire logic        [COORD_BITS-1:0] box_height,
    input  wire logic        [CLASS_W-1:0]    box_class,
    input  wire logic                         first_box,
    // configuration writes
    input  wire logic                         cfg_we,
    input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [CFG_DAT_W-1:0]  cfg_data,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              kept,
    output logic             [SLOT_W-1:0]     kept_slot,
    output logic                              list_full_drop
);

    localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W = $clog2(MAX_KEPT + 1);
    localparam int E_W   = COORD_BITS + 2;       // edge coordinate, no wrap
    localparam int A_W   = 2 * COORD_BITS;       // area / intersection
    localparam int U_W   = A_W + 1;              // union
    localparam int L_W   = A_W + 8;              // intersection * 256
    localparam int P_W   = U_W + THR_W;          // threshold * union

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_KEPT);

    // Configuration registers
    logic [THR_W-1:0] thr_reg;
    logic             agn_reg;

    // Kept list storage, undefined until written
    logic signed [E_W-1:0]     mem_left   [MAX_KEPT];
    logic signed [E_W-1:0]     mem_top    [MAX_KEPT];
    logic signed [E_W-1:0]     mem_right  [MAX_KEPT];
    logic signed [E_W-1:0]     mem_bottom [MAX_KEPT];
    logic        [CLASS_W-1:0] mem_label  [MAX_KEPT];
    logic        [A_W-1:0]     mem_area   [MAX_KEPT];

    logic [CNT_W-1:0] kept_count_reg;
    logic [CNT_W-1:0] scan_idx_reg;

    // Candidate registers
    logic signed [E_W-1:0]     cand_left_reg;
    logic signed [E_W-1:0]     cand_top_reg;
    logic signed [E_W-1:0]     cand_right_reg;
    logic signed [E_W-1:0]     cand_bottom_reg;
    logic        [CLASS_W-1:0] cand_cls_reg;
    logic        [A_W-1:0]     cand_area_reg;
    logic signed [E_W-1:0]     left_ext;
    logic signed [E_W-1:0]     top_ext;

    // Pipe stage 1: read data
    logic                      v1_reg;
    logic signed [E_W-1:0]     rd_left_reg;
    logic signed [E_W-1:0]     rd_top_reg;
    logic signed [E_W-1:0]     rd_right_reg;
    logic signed [E_W-1:0]     rd_bottom_reg;
    logic        [CLASS_W-1:0] rd_label_reg;
    logic        [A_W-1:0]     rd_area_reg;

    // Stage 1 overlap logic
    logic signed [E_W-1:0]     x_lo;
    logic signed [E_W-1:0]     x_hi;
    logic signed [E_W-1:0]     y_lo;
    logic signed [E_W-1:0]     y_hi;
    logic signed [E_W:0]       x_diff;
    logic signed [E_W:0]       y_diff;
    logic [COORD_BITS-1:0]     ov_x;
    logic [COORD_BITS-1:0]     ov_y;

    // Stage 2..5 registers
    logic                  v2_reg;
    logic                  m2_reg;
    logic [COORD_BITS-1:0] ovx2_reg;
    logic [COORD_BITS-1:0] ovy2_reg;
    logic [A_W-1:0]        karea2_reg;

    logic                  v3_reg;
    logic                  m3_reg;
    logic [A_W-1:0]        inter3_reg;
    logic [A_W-1:0]        karea3_reg;

    logic                  v4_reg;
    logic                  m4_reg;
    logic [A_W-1:0]        inter4_reg;
    logic [U_W-1:0]        uni4_reg;

    logic                  v5_reg;
    logic                  m5_reg;
    logic [L_W-1:0]        lhs5_reg;
    logic [P_W-1:0]        rhs5_reg;

    logic                  suppress_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  kept_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  drop_reg;
    logic                  list_full;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= IOU_THR_RESET;
            agn_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IOU_THRESHOLD:  thr_reg <= cfg_data[THR_W-1:0];
                REG_CLASS_AGNOSTIC: agn_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Candidate latch: edges at full precision, area
    assign left_ext = E_W'(box_left);
    assign top_ext  = E_W'(box_top);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cand_left_reg   <= left_ext;
            cand_top_reg    <= top_ext;
            cand_right_reg  <= left_ext + $signed({2'b00, box_width});
            cand_bottom_reg <= top_ext + $signed({2'b00, box_height});
            cand_cls_reg    <= box_class;
            cand_area_reg   <= A_W'(box_width) * A_W'(box_height);
        end
    end

    // List count and scan pointer
    assign list_full = (kept_count_reg == FULL_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count_reg <= '0;
            scan_idx_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                if (first_box)
                    kept_count_reg <= '0;
            end
            else if (cmd.issue)
                scan_idx_reg <= scan_idx_reg + 1'b1;
            if (cmd.commit && !suppress_reg && !list_full)
                kept_count_reg <= kept_count_reg + 1'b1;
        end
    end

    // Memory: append on commit, registered read on issue
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !suppress_reg && !list_full)
        begin
            mem_left[kept_count_reg[IDX_W-1:0]]   <= cand_left_reg;
            mem_top[kept_count_reg[IDX_W-1:0]]    <= cand_top_reg;
            mem_right[kept_count_reg[IDX_W-1:0]]  <= cand_right_reg;
            mem_bottom[kept_count_reg[IDX_W-1:0]] <= cand_bottom_reg;
            mem_label[kept_count_reg[IDX_W-1:0]]  <= cand_cls_reg;
            mem_area[kept_count_reg[IDX_W-1:0]]   <= cand_area_reg;
        end
        if (cmd.issue)
        begin
            rd_left_reg   <= mem_left[scan_idx_reg[IDX_W-1:0]];
            rd_top_reg    <= mem_top[scan_idx_reg[IDX_W-1:0]];
            rd_right_reg  <= mem_right[scan_idx_reg[IDX_W-1:0]];
            rd_bottom_reg <= mem_bottom[scan_idx_reg[IDX_W-1:0]];
            rd_label_reg  <= mem_label[scan_idx_reg[IDX_W-1:0]];
            rd_area_reg   <= mem_area[scan_idx_reg[IDX_W-1:0]];
        end
    end

    // Stage 1: 1-D overlaps, zero when disjoint or touching
    always_comb
    begin
        x_lo   = (cand_left_reg > rd_left_reg) ? cand_left_reg : rd_left_reg;
        x_hi   = (cand_right_reg < rd_right_reg) ? cand_right_reg : rd_right_reg;
        y_lo   = (cand_top_reg > rd_top_reg) ? cand_top_reg : rd_top_reg;
        y_hi   = (cand_bottom_reg < rd_bottom_reg) ? cand_bottom_reg : rd_bottom_reg;
        x_diff = (E_W+1)'(x_hi) - (E_W+1)'(x_lo);
        y_diff = (E_W+1)'(y_hi) - (E_W+1)'(y_lo);
        ov_x   = (x_diff > 0) ? x_diff[COORD_BITS-1:0] : '0;
        ov_y   = (y_diff > 0) ? y_diff[COORD_BITS-1:0] : '0;
    end

    // Stages 2..5 payload: product, union, threshold product, compare inputs
    always_ff @(posedge clk)
    begin
        m2_reg     <= agn_reg || (rd_label_reg == cand_cls_reg);
        ovx2_reg   <= ov_x;
        ovy2_reg   <= ov_y;
        karea2_reg <= rd_area_reg;

        m3_reg     <= m2_reg;
        inter3_reg <= A_W'(ovx2_reg) * A_W'(ovy2_reg);
        karea3_reg <= karea2_reg;

        m4_reg     <= m3_reg;
        inter4_reg <= inter3_reg;
        uni4_reg   <= U_W'(cand_area_reg) + U_W'(karea3_reg) - U_W'(inter3_reg);

        m5_reg     <= m4_reg;
        lhs5_reg   <= {inter4_reg, 8'd0};
        rhs5_reg   <= P_W'(thr_reg) * P_W'(uni4_reg);
    end

    // Pipe valid bits and suppression flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            suppress_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (cmd.load)
                suppress_reg <= 1'b0;
            else if (v5_reg && m5_reg && (P_W'(lhs5_reg) > rhs5_reg))
                suppress_reg <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            kept_reg <= !suppress_reg && !list_full;
            slot_reg <= (!suppress_reg && !list_full) ? SLOT_W'(kept_count_reg) : '0;
            drop_reg <= !suppress_reg && list_full;
        end
    end

    // Status and outputs
    always_comb
    begin
        stat.scan_done = (scan_idx_reg == kept_count_reg);
        stat.pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign kept           = kept_reg;
    assign kept_slot      = slot_reg;
    assign list_full_drop = drop_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for greedy_box_suppression_unit. Score-sorted candidate
// frames are streamed in bursts while the result side stalls on its own
// pattern. A behavioral copy of the kept list predicts every keep, slot and
// full-list drop decision, and each result beat is checked against it.
// Threshold and class mode change between phases, only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import gbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = MAX_KEPT_DEF;
    localparam int STALL_LIMIT = 1000;   // cycles with no beat on any channel
    localparam int DRAIN_WAIT  = MAX_KEPT_DEF + 16;
    localparam int GRID_CELLS  = 80;

    // Index outside the register map, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd9;

    typedef struct {
        logic signed [COORD_BITS_DEF-1:0] left;
        logic signed [COORD_BITS_DEF-1:0] top;
        logic        [COORD_BITS_DEF-1:0] width;
        logic        [COORD_BITS_DEF-1:0] height;
        logic        [CLASS_W-1:0]        cls;
        logic                             first;
    } box_t;

    typedef struct {
        logic              kept;
        logic [SLOT_W-1:0] slot;
        logic              drop;
    } decision_t;

    logic clk;
    logic rst_n;

    gbs_box_if #(.COORD_BITS(COORD_BITS_DEF)) cand_if ();
    gbs_result_if                             res_if ();
    gbs_cfg_if                                cfg_if ();

    greedy_box_suppression_unit #(
        .MAX_KEPT   (MAX_KEPT_DEF),
        .COORD_BITS (COORD_BITS_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (cand_if),
        .result    (res_if),
        .cfg       (cfg_if)
    );

    // Stimulus and scoreboard storage
    box_t      pending_boxes[$];
    decision_t expected_decisions[$];
    int        boxes_issued;
    int        boxes_accepted;
    int        mismatch_count;
    int        idle_cycles;
    logic      box_taken;
    logic      cfg_taken;

    // Behavioral copy of the kept list and the registers
    longint    list_left[LIST_DEPTH];
    longint    list_top[LIST_DEPTH];
    longint    list_width[LIST_DEPTH];
    longint    list_height[LIST_DEPTH];
    int        list_cls[LIST_DEPTH];
    int        list_count;
    int        iou_limit;
    bit        all_classes;

    // Frame layout scratch
    int        ctr_left[GRID_CELLS];
    int        ctr_top[GRID_CELLS];
    int        ctr_width[GRID_CELLS];
    int        ctr_height[GRID_CELLS];
    int        ctr_cls[GRID_CELLS];

    // Traffic shaping
    int        burst_left;
    int        gap_left;
    int        run_left;
    int        stall_left;
    box_t      next_box;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint span_overlap(longint a0, longint al, longint b0, longint bl);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic decision_t judge_box(box_t b);
        longint    l;
        longint    t;
        longint    w;
        longint    h;
        longint    area;
        longint    inter;
        longint    uni;
        bit        survives;
        decision_t d;
        l = b.left;
        t = b.top;
        w = b.width;
        h = b.height;
        area = w * h;
        survives = 1'b1;
        if (b.first)
            list_count = 0;
        for (int j = 0; j < list_count; j++)
        begin
            if (!all_classes && list_cls[j] != b.cls)
                continue;
            inter = span_overlap(l, w, list_left[j], list_width[j]) *
                    span_overlap(t, h, list_top[j], list_height[j]);
            uni = area + list_width[j] * list_height[j] - inter;
            if (inter * 256 > longint'(iou_limit) * uni)
                survives = 1'b0;
        end
        d = '{kept: 1'b0, slot: '0, drop: 1'b0};
        if (survives)
        begin
            if (list_count < LIST_DEPTH)
            begin
                list_left[list_count]   = l;
                list_top[list_count]    = t;
                list_width[list_count]  = w;
                list_height[list_count] = h;
                list_cls[list_count]    = b.cls;
                d.kept = 1'b1;
                d.slot = SLOT_W'(list_count);
                list_count++;
            end
            else
                d.drop = 1'b1;
        end
        return d;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts on candidate beats, checks result beats
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        box_taken <= cand_if.valid && cand_if.ready;
        cfg_taken <= cfg_if.valid && cfg_if.ready;
        if ((cand_if.valid && cand_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;

        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
        begin
            // register writes
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.index)
                    REG_IOU_THRESHOLD:  iou_limit = cfg_if.data;
                    REG_CLASS_AGNOSTIC: all_classes = cfg_if.data[0];
                    default: ;
                endcase
            end

            // result beat against the oldest prediction
            if (res_if.valid && res_if.ready)
            begin
                if (expected_decisions.size() == 0)
                    report_mismatch("result beat with no pending box", 1, 0);
                else
                begin
                    decision_t want;
                    want = expected_decisions.pop_front();
                    if (res_if.kept !== want.kept)
                        report_mismatch("kept", res_if.kept, want.kept);
                    if (res_if.kept_slot !== want.slot)
                        report_mismatch("kept_slot", res_if.kept_slot, want.slot);
                    if (res_if.list_full_drop !== want.drop)
                        report_mismatch("list_full_drop", res_if.list_full_drop, want.drop);
                end
            end

            // candidate beat
            if (cand_if.valid && cand_if.ready)
            begin
                box_t b;
                b.left   = cand_if.box_left;
                b.top    = cand_if.box_top;
                b.width  = cand_if.box_width;
                b.height = cand_if.box_height;
                b.cls    = cand_if.box_class;
                b.first  = cand_if.first_box;
                expected_decisions.insert(expected_decisions.size(), judge_box(b));
                boxes_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Candidate driver: bursts with random gaps
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cand_if.valid && !box_taken)
            begin
                // beat still waiting, hold it
            end
            else if (gap_left > 0)
            begin
                cand_if.valid <= 1'b0;
                gap_left--;
            end
            else if (pending_boxes.size() > 0)
            begin
                next_box = pending_boxes.pop_front();
                cand_if.box_left   <= next_box.left;
                cand_if.box_top    <= next_box.top;
                cand_if.box_width  <= next_box.width;
                cand_if.box_height <= next_box.height;
                cand_if.box_class  <= next_box.cls;
                cand_if.first_box  <= next_box.first;
                cand_if.valid      <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                cand_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: ready runs broken by stalls
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_if.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            res_if.ready <= 1'b1;
            if (run_left > 0)
                run_left--;
            else
            begin
                run_left   = $urandom_range(0, 30);
                stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_box(int l, int t, int w, int h, int c, bit f);
        box_t b;
        b.left   = COORD_BITS_DEF'(l);
        b.top    = COORD_BITS_DEF'(t);
        b.width  = COORD_BITS_DEF'(w);
        b.height = COORD_BITS_DEF'(h);
        b.cls    = CLASS_W'(c);
        b.first  = f;
        pending_boxes.insert(pending_boxes.size(), b);
        boxes_issued++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        cfg_if.valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_if.valid <= 1'b0;
    endtask

    // Block idle: every box taken and every decision returned
    task automatic wait_idle();
        while (pending_boxes.size() != 0 || boxes_accepted != boxes_issued ||
               expected_decisions.size() != 0)
            @(negedge clk);
    endtask

    // One frame: first box clears the list, most of the rest jitter around anchors.
    // Spread frames place anchors on a disjoint grid so the list can fill.
    task automatic add_frame(int n, bit spread);
        int n_ctr;
        int k;
        bit f;
        n_ctr = spread ? GRID_CELLS : $urandom_range(1, 8);
        for (int i = 0; i < n_ctr; i++)
        begin
            if (spread)
            begin
                ctr_left[i]   = (i % 10) * 2000 - 10000;
                ctr_top[i]    = (i / 10) * 2000 - 10000;
                ctr_width[i]  = $urandom_range(32, 1500);
                ctr_height[i] = $urandom_range(32, 1500);
            end
            else
            begin
                ctr_left[i]   = int'($urandom_range(0, 40000)) - 20000;
                ctr_top[i]    = int'($urandom_range(0, 40000)) - 20000;
                ctr_width[i]  = $urandom_range(32, 4000);
                ctr_height[i] = $urandom_range(32, 4000);
            end
            ctr_cls[i] = $urandom_range(0, 3);
        end
        for (int i = 0; i < n; i++)
        begin
            f = (i == 0) || ($urandom_range(0, 49) == 0);
            if ($urandom_range(0, 9) == 0)
                // noise over the whole field range
                push_box(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                         int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                         int'($urandom_range(0, 255)), f);
            else
            begin
                k = spread ? (i % n_ctr) : $urandom_range(0, n_ctr - 1);
                push_box(ctr_left[k] + int'($urandom_range(0, 128)) - 64,
                         ctr_top[k] + int'($urandom_range(0, 128)) - 64,
                         ctr_width[k] + int'($urandom_range(0, 64)) - 32,
                         ctr_height[k] + int'($urandom_range(0, 64)) - 32,
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : ctr_cls[k],
                         f);
            end
        end
    endtask

    // Random phase under one register setting
    task automatic run_phase(int thr, logic [CFG_DAT_W-1:0] agn_data, int n_items);
        int queued;
        int n;
        wait_idle();
        write_reg(REG_IOU_THRESHOLD, CFG_DAT_W'(thr));
        write_reg(REG_CLASS_AGNOSTIC, agn_data);
        queued = 0;
        while (queued < n_items)
        begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(65, 90) : $urandom_range(2, 30);
            add_frame(n, (n > 60) || ($urandom_range(0, 3) == 0));
            queued += n;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        cand_if.valid      = 1'b0;
        cand_if.box_left   = '0;
        cand_if.box_top    = '0;
        cand_if.box_width  = '0;
        cand_if.box_height = '0;
        cand_if.box_class  = '0;
        cand_if.first_box  = 1'b0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        box_taken          = 1'b0;
        cfg_taken          = 1'b0;
        boxes_issued       = 0;
        boxes_accepted     = 0;
        mismatch_count     = 0;
        idle_cycles        = 0;
        list_count         = 0;
        iou_limit          = IOU_THR_RESET;
        all_classes        = 1'b0;
        burst_left         = 0;
        gap_left           = 0;
        run_left           = 0;
        stall_left         = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset settings (threshold 115, class-aware)
        push_box(0, 0, 160, 160, 1, 1'b1);               // first box, slot 0
        push_box(0, 0, 160, 160, 1, 1'b0);               // duplicate, suppressed
        push_box(0, 0, 160, 160, 2, 1'b0);               // other class survives
        push_box(160, 0, 160, 160, 1, 1'b0);             // touching edge
        push_box(-32768, -32768, 16, 16, 1, 1'b0);       // far corner, disjoint
        push_box(32, 0, 160, 160, 1, 1'b0);              // heavy overlap
        push_box(96, 0, 160, 160, 1, 1'b0);              // light overlap
        push_box(500, 500, 0, 0, 7, 1'b0);               // zero area
        push_box(500, 500, 0, 0, 7, 1'b0);               // both zero: union zero
        push_box(32767, 32767, 65535, 65535, 255, 1'b0); // right edge past range
        push_box(32767, 32767, 65535, 65535, 255, 1'b0); // same, suppressed
        push_box(-100, -200, 0, 65535, 0, 1'b0);
        push_box(0, 0, 160, 160, 1, 1'b1);               // clear mid-stream
        push_box(0, 0, 160, 160, 1, 1'b0);
        wait_idle();

        // Directed, any overlap suppresses across classes
        write_reg(REG_IOU_THRESHOLD, 9'd0);
        write_reg(REG_CLASS_AGNOSTIC, 9'd1);
        write_reg(REG_SPARE, 9'h1FF);
        push_box(0, 0, 160, 160, 3, 1'b1);
        push_box(159, 159, 16, 16, 9, 1'b0);             // one unit of overlap
        push_box(160, 160, 16, 16, 9, 1'b0);             // corner touch
        push_box(-16, -16, 16, 16, 200, 1'b0);
        wait_idle();

        // Random phases across register settings
        run_phase(IOU_THR_RESET, 9'd0, 110);
        run_phase(0, 9'd1, 100);
        run_phase(256, 9'd0, 110);
        run_phase(511, 9'd1, 110);
        run_phase(1, 9'd0, 100);
        run_phase(255, 9'h1FE, 100);                     // upper data bits ignored
        run_phase($urandom_range(2, 254), 9'($urandom_range(0, 1)), 120);
        run_phase(IOU_THR_RESET, 9'h1FF, 120);

        wait_idle();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatch_count == 0 && expected_decisions.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
